// ===== design/indexed_set_random_sample_macros.svh =====
// Assertion macros shared by the indexed set checker
`ifndef INDEXED_SET_RANDOM_SAMPLE_MACROS_SVH
`define INDEXED_SET_RANDOM_SAMPLE_MACROS_SVH

// same-cycle implication, checked outside reset
`define ISRS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define ISRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/isrs_pkg.sv =====
// Types, codes and defaults for the indexed set with random sampling
`timescale 1ns / 1ps
`default_nettype none

package isrs_pkg;

	localparam int CAPACITY_DEF = 256;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_GET    = 2'd2;

	localparam logic [2:0] STAT_OK      = 3'd0;
	localparam logic [2:0] STAT_PRESENT = 3'd1;
	localparam logic [2:0] STAT_ABSENT  = 3'd2;
	localparam logic [2:0] STAT_EMPTY   = 3'd3;
	localparam logic [2:0] STAT_FULL    = 3'd4;

	localparam int VALUE_W  = 32;
	localparam int RANDOM_W = 31;

	typedef struct packed {
		logic [1:0]                opcode;
		logic signed [VALUE_W-1:0] value;
		logic [RANDOM_W-1:0]       random_word;
	} req_t;

	typedef struct packed {
		logic                      success;
		logic [2:0]                status;
		logic signed [VALUE_W-1:0] element;
	} rsp_t;

endpackage

`default_nettype wire

// ===== design/isrs_ram.sv =====
// Generic simple dual-port RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none

module isrs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== design/isrs_divider.sv =====
// Restoring remainder unit, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module isrs_divider #(
	parameter int DW = 31,
	parameter int CW = 9,
	localparam int CNTW = $clog2(DW + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          go,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [CW-1:0] divisor,
	output logic               done,
	output logic      [CW-1:0] rem
);

	logic [CNTW-1:0] cnt_q;
	logic [DW-1:0]   dvd_q;
	logic [CW-1:0]   dvs_q;
	logic [CW-1:0]   rem_q;
	logic            done_q;
	logic [CW:0]     trial;
	logic [CW:0]     diff;

	assign trial = {rem_q, dvd_q[DW-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				cnt_q <= CNTW'(DW);
				dvd_q <= dividend;
				dvs_q <= divisor;
				rem_q <= '0;
			end else if (cnt_q != '0) begin
				// remainder stays below the divisor, so CW bits hold it
				if (trial >= {1'b0, dvs_q}) begin
					rem_q <= diff[CW-1:0];
				end else begin
					rem_q <= trial[CW-1:0];
				end
				dvd_q <= dvd_q << 1;
				cnt_q <= cnt_q - CNTW'(1);
				done_q <= (cnt_q == CNTW'(1));
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

// ===== design/indexed_set_random_sample.sv =====
// Top level: indexed set with insert, remove and random sampling
//
//  channel   handshake          payload       direction
//  request   start / busy       req (req_t)   in
//  response  done (strobe)      rsp (rsp_t)   out
//
// Insert and remove scan the packed store one entry per cycle through the
// RAM read port; a remove that frees a slot other than the last moves the
// last entry into it. Get random runs the remainder unit, then one RAM
// read. busy is high from the cycle after start until the done beat;
// reset clears the count, so no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module indexed_set_random_sample #(
	parameter int CAPACITY = isrs_pkg::CAPACITY_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire isrs_pkg::req_t req,
	output logic               done,
	output isrs_pkg::rsp_t     rsp
);

	import isrs_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DISPATCH = 3'd1;
	localparam logic [2:0] S_SCAN     = 3'd2;
	localparam logic [2:0] S_MOVE_RD  = 3'd3;
	localparam logic [2:0] S_MOVE_WR  = 3'd4;
	localparam logic [2:0] S_DIV      = 3'd5;
	localparam logic [2:0] S_GET_RD   = 3'd6;
	localparam logic [2:0] S_GET_WAIT = 3'd7;

	logic [2:0]         state_q;
	req_t               req_q;
	rsp_t               rsp_q;
	logic               done_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      idx_q;
	logic [AW-1:0]      idx_s1;
	logic               vld_s1;
	logic [AW-1:0]      slot_q;

	logic [CW-1:0]      last;
	logic [AW-1:0]      last_addr;
	logic               full;
	logic               issue;
	logic               hit;
	logic               miss;

	logic               we;
	logic [AW-1:0]      waddr;
	logic [VALUE_W-1:0] wdata;
	logic [AW-1:0]      raddr;
	logic [VALUE_W-1:0] rdata;

	logic               div_go;
	logic               div_done;
	logic [CW-1:0]      div_rem;

	assign last      = count_q - CW'(1);
	assign last_addr = last[AW-1:0];
	assign full      = (count_q == CW'(CAPACITY));
	assign issue     = (idx_q < count_q);
	assign hit       = vld_s1 && (rdata == $unsigned(req_q.value));
	assign miss      = !issue && !vld_s1;
	assign div_go    = (state_q == S_DISPATCH) && (req_q.opcode == OP_GET) && (count_q != '0);

	always_comb begin
		we    = 1'b0;
		waddr = count_q[AW-1:0];
		wdata = $unsigned(req_q.value);
		raddr = idx_q[AW-1:0];
		unique case (state_q)
			S_SCAN: begin
				// append on a miss when there is room
				we = !hit && miss && (req_q.opcode == OP_INSERT) && !full;
			end
			S_MOVE_RD: begin
				raddr = last_addr;
			end
			S_MOVE_WR: begin
				we    = 1'b1;
				waddr = slot_q;
				wdata = rdata;
			end
			S_GET_RD: begin
				raddr = div_rem[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	isrs_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	isrs_divider #(
		.DW(RANDOM_W),
		.CW(CW)
	) u_divider (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (div_go),
		.dividend(req_q.random_word),
		.divisor (count_q),
		.done    (div_done),
		.rem     (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			count_q <= '0;
			vld_s1  <= 1'b0;
			idx_q   <= '0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q   <= req;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					idx_q <= '0;
					priority if (req_q.opcode == OP_INSERT || req_q.opcode == OP_REMOVE) begin
						state_q <= S_SCAN;
					end else if (req_q.opcode == OP_GET) begin
						if (count_q == '0) begin
							rsp_q   <= '{success: 1'b0, status: STAT_EMPTY, element: '0};
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_DIV;
						end
					end else begin
						// unused opcode: drop with a plain status
						rsp_q   <= '{success: 1'b0, status: STAT_OK, element: '0};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					vld_s1 <= issue && !hit;
					idx_s1 <= idx_q[AW-1:0];
					if (issue) begin
						idx_q <= idx_q + CW'(1);
					end
					priority if (hit) begin
						vld_s1 <= 1'b0;
						if (req_q.opcode == OP_INSERT) begin
							rsp_q   <= '{success: 1'b0, status: STAT_PRESENT, element: '0};
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else if (idx_s1 == last_addr) begin
							count_q <= last;
							rsp_q   <= '{success: 1'b1, status: STAT_OK, element: '0};
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							slot_q  <= idx_s1;
							state_q <= S_MOVE_RD;
						end
					end else if (miss) begin
						if (req_q.opcode == OP_REMOVE) begin
							rsp_q <= '{success: 1'b0, status: STAT_ABSENT, element: '0};
						end else if (full) begin
							rsp_q <= '{success: 1'b0, status: STAT_FULL, element: '0};
						end else begin
							count_q <= count_q + CW'(1);
							rsp_q   <= '{success: 1'b1, status: STAT_OK, element: '0};
						end
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						// hold until the scan settles
					end
				end
				S_MOVE_RD: begin
					state_q <= S_MOVE_WR;
				end
				S_MOVE_WR: begin
					count_q <= last;
					rsp_q   <= '{success: 1'b1, status: STAT_OK, element: '0};
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_GET_RD;
					end
				end
				S_GET_RD: begin
					state_q <= S_GET_WAIT;
				end
				S_GET_WAIT: begin
					rsp_q   <= '{success: 1'b1, status: STAT_OK, element: $signed(rdata)};
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

`default_nettype wire

// ===== design/isrs_checker.sv =====
// Port-level checks for the indexed set, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "indexed_set_random_sample_macros.svh"

module isrs_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           start,
	input wire logic           busy,
	input wire logic           done,
	input wire isrs_pkg::rsp_t rsp
);

	import isrs_pkg::*;

	logic accepted;

	assign accepted = start && !busy;

	`ISRS_ASSERT_NEXT(a_accept_busy, accepted, busy, "accepted beat did not raise busy")
	`ISRS_ASSERT_NOW(a_done_ends_busy, 1'b1, done == $fell(busy), "done beat and busy drop disagree")
	`ISRS_ASSERT_NOW(a_success_ok, done && rsp.success, rsp.status == STAT_OK, "success with bad status")
	`ISRS_ASSERT_NOW(a_fail_zero, done && !rsp.success, rsp.element == '0, "failed beat carries element")

endmodule

bind indexed_set_random_sample isrs_checker u_isrs_checker (.*);

`default_nettype wire

// ===== verif/testbench.sv =====
// Testbench for the indexed set: directed cases, fill to capacity, random churn
`timescale 1ns / 1ps

module testbench;
	import isrs_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PRINT_CAP = 40;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	req_t req;
	rsp_t rsp;

	// mirror of the set contents, packed the same way as the block keeps them
	logic signed [VALUE_W-1:0] set_values [CAPACITY_DEF];
	int set_count;
	rsp_t expected_outcomes [$];
	int error_count;
	int cycle_count;
	bit steady_feed;

	indexed_set_random_sample uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL indexed_set_random_sample");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		if (error_count < PRINT_CAP)
			$display("[%0t] mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic int find_value(input logic signed [VALUE_W-1:0] v);
		for (int i = 0; i < set_count; i++)
			if (set_values[i] == v)
				return i;
		return -1;
	endfunction

	// update the mirror and return the response the block owes for this request
	function automatic rsp_t predict_set_op(input req_t item);
		rsp_t out;
		int slot;
		out = '0;
		out.status = STAT_OK;
		slot = find_value(item.value);
		case (item.opcode)
			OP_INSERT: begin
				if (slot >= 0)
					out.status = STAT_PRESENT;
				else if (set_count >= CAPACITY_DEF)
					out.status = STAT_FULL;
				else begin
					set_values[set_count] = item.value;
					set_count++;
					out.success = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (slot < 0)
					out.status = STAT_ABSENT;
				else begin
					set_values[slot] = set_values[set_count - 1];
					set_count--;
					out.success = 1'b1;
				end
			end
			OP_GET: begin
				if (set_count == 0)
					out.status = STAT_EMPTY;
				else begin
					out.element = set_values[int'(item.random_word) % set_count];
					out.success = 1'b1;
				end
			end
			default: ;
		endcase
		return out;
	endfunction

	always @(posedge clk) begin : check_beat
		rsp_t want;
		if (arst_n && done) begin
			if (expected_outcomes.size() == 0)
				report_mismatch($sformatf("unexpected beat %0d/%0d/%h",
					rsp.success, rsp.status, rsp.element));
			else begin
				want = expected_outcomes.pop_front();
				if (rsp.success !== want.success)
					report_mismatch($sformatf("success got %b want %b",
						rsp.success, want.success));
				if (rsp.status !== want.status)
					report_mismatch($sformatf("status got %0d want %0d",
						rsp.status, want.status));
				if (rsp.element !== want.element)
					report_mismatch($sformatf("element got %h want %h",
						rsp.element, want.element));
			end
		end
	end

	task automatic maybe_idle();
		if (!steady_feed && $urandom_range(0, 99) < 21) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
	endtask

	// hold the request until the block takes it, then record what it owes
	task automatic send_item(input logic [1:0] op, input logic signed [VALUE_W-1:0] val,
			input logic [RANDOM_W-1:0] rw);
		req_t item;
		item.opcode = op;
		item.value = val;
		item.random_word = rw;
		req <= item;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		expected_outcomes.insert(expected_outcomes.size(), predict_set_op(item));
		maybe_idle();
	endtask

	// always advance at least one edge so start is not driven twice in one step
	task automatic wait_for_results();
		start <= 1'b0;
		do @(posedge clk); while (expected_outcomes.size() != 0);
	endtask

	function automatic logic signed [VALUE_W-1:0] pick_present();
		return set_values[$urandom_range(0, set_count - 1)];
	endfunction

	function automatic logic signed [VALUE_W-1:0] pick_absent();
		logic signed [VALUE_W-1:0] v;
		do v = $urandom; while (find_value(v) >= 0);
		return v;
	endfunction

	function automatic logic [RANDOM_W-1:0] any_word();
		return RANDOM_W'($urandom);
	endfunction

	task automatic test_directed();
		send_item(OP_GET, 32'sd0, '0);                  // get on empty set
		send_item(OP_REMOVE, 32'sd5, any_word());       // remove from empty set
		send_item(OP_INSERT, 32'sh8000_0000, any_word());
		send_item(OP_INSERT, 32'sh7fff_ffff, any_word());
		send_item(OP_INSERT, 32'sd0, any_word());
		send_item(OP_INSERT, -32'sd1, any_word());
		send_item(OP_INSERT, 32'sh8000_0000, any_word()); // already present
		send_item(OP_GET, 32'sd0, '0);
		send_item(OP_GET, 32'sd0, '1);
		send_item(OP_GET, 32'sd0, 31'd5);
		send_item(OP_REMOVE, 32'sh7fff_ffff, any_word()); // last entry moves up
		send_item(OP_GET, 32'sd0, 31'd1);
		send_item(OP_REMOVE, -32'sd1, any_word());
		send_item(OP_REMOVE, 32'sd0, any_word());       // removes the last entry
		send_item(OP_REMOVE, 32'sd0, any_word());       // now absent
		send_item(OP_GET, -32'sd1, any_word());         // value ignored on get
		send_item(OP_UNUSED, $urandom, any_word());
		send_item(OP_UNUSED, -32'sd1, '1);
		send_item(OP_REMOVE, 32'sh8000_0000, any_word());
		send_item(OP_GET, $urandom, any_word());        // empty again
		send_item(OP_INSERT, 32'sh5555_5555, any_word());
		send_item(OP_INSERT, 32'shaaaa_aaaa, any_word());
		send_item(OP_GET, 32'sd0, 31'd1);
	endtask

	task automatic test_fill_to_capacity();
		while (set_count < CAPACITY_DEF) begin
			if ($urandom_range(0, 9) == 0)
				send_item(OP_GET, $urandom, any_word());
			else
				send_item(OP_INSERT, pick_absent(), any_word());
		end
		send_item(OP_INSERT, pick_absent(), any_word());  // full
		send_item(OP_INSERT, pick_present(), any_word()); // presence wins over full
		send_item(OP_GET, $urandom, '1);
		send_item(OP_GET, $urandom, '0);
		send_item(OP_REMOVE, pick_absent(), any_word());
		send_item(OP_REMOVE, set_values[CAPACITY_DEF - 1], any_word());
		send_item(OP_REMOVE, set_values[0], any_word());
		send_item(OP_INSERT, pick_absent(), any_word());
		send_item(OP_INSERT, pick_absent(), any_word());
		send_item(OP_INSERT, pick_absent(), any_word());  // full again
		wait_for_results();
	endtask

	task automatic test_random_churn();
		logic signed [VALUE_W-1:0] pool [16];
		logic signed [VALUE_W-1:0] v;
		int roll;
		int insert_pct;
		int remove_pct;
		foreach (pool[i])
			pool[i] = $urandom;
		for (int n = 0; n < 240; n++) begin
			steady_feed = (n >= 60 && n < 160);
			// shrink the set first, then hold it near a steady size
			insert_pct = (n < 120) ? 20 : 38;
			remove_pct = (n < 120) ? 55 : 35;
			if (n == 170)
				wait_for_results();
			roll = $urandom_range(0, 99);
			if (roll < insert_pct) begin
				roll = $urandom_range(0, 9);
				if (roll < 2 && set_count > 0)
					v = pick_present();
				else if (roll < 5)
					v = pool[$urandom_range(0, 15)];
				else
					v = $urandom;
				send_item(OP_INSERT, v, any_word());
			end else if (roll < insert_pct + remove_pct) begin
				roll = $urandom_range(0, 9);
				if (roll < 7 && set_count > 0)
					v = pick_present();
				else if (roll < 9)
					v = pool[$urandom_range(0, 15)];
				else
					v = $urandom;
				send_item(OP_REMOVE, v, any_word());
			end else if (roll < 97)
				send_item(OP_GET, $urandom, any_word());
			else
				send_item(OP_UNUSED, $urandom, any_word());
		end
		steady_feed = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		set_count = 0;
		error_count = 0;
		cycle_count = 0;
		steady_feed = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_to_capacity();
		test_random_churn();

		wait_for_results();
		// catch any stray beat after the last expected one
		repeat (300) @(posedge clk);
		if (error_count == 0)
			$display("PASS indexed_set_random_sample");
		else
			$display("FAIL indexed_set_random_sample");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/isrs_pkg.sv
design/isrs_ram.sv
design/isrs_divider.sv
design/indexed_set_random_sample.sv
design/isrs_checker.sv
verif/testbench.sv
